// ----- src/sstf_disk_scheduler_top_defines.svh -----
// Assertion macros used by the scheduler datapath (sstf_dp).
`ifndef SSTF_DISK_SCHEDULER_TOP_DEFINES_SVH
`define SSTF_DISK_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSTF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSTF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sstf_pkg.sv -----
// Package with the scheduler's controller state, command and status types.
package sstf_pkg;

  localparam int FIELD_W = 16;
  localparam int TOTAL_W = 22;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // write the incoming track into the table
    logic batch_start;  // head from head_start, clear total and pick count
    logic scan_clear;   // restart the nearest-request scan
    logic scan_rd;      // read the next table entry for the scan
    logic commit;       // serve the best entry and load the output register
    logic batch_end;    // clear count, dropped flag and served marks
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;    // the scan reads the last loaded entry this cycle
    logic pick_last;    // the pending pick is the last of the batch
    logic out_free;     // the output register can take a word this cycle
  } sts_t;

endpackage

// ----- src/sstf_ctrl.sv -----
// Controller state machine that sequences loading, scanning and serving.
module sstf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  input  sstf_pkg::sts_t sts,
  output sstf_pkg::cmd_t cmd
);

  sstf_pkg::state_t state;
  sstf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sstf_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      sstf_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.batch_start = 1'b1;
            cmd.scan_clear  = 1'b1;
            state_next      = sstf_pkg::ST_SCAN;
          end
        end
      end
      sstf_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = sstf_pkg::ST_WAIT;
        end
      end
      sstf_pkg::ST_WAIT: begin
        // The compare stage takes in the last entry read.
        state_next = sstf_pkg::ST_EMIT;
      end
      sstf_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          if (sts.pick_last) begin
            cmd.batch_end = 1'b1;
            state_next    = sstf_pkg::ST_LOAD;
          end else begin
            cmd.scan_clear = 1'b1;
            state_next     = sstf_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_next = sstf_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ----- src/sstf_dp.sv -----
// Datapath: request table, served marks, nearest-request scan and output register.
`include "sstf_disk_scheduler_top_defines.svh"

module sstf_dp #(
  parameter int MAX_REQ    = 64,
  parameter int TRACK_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sstf_pkg::cmd_t                  cmd,
  output sstf_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [sstf_pkg::FIELD_W-1:0]    cfg_data,
  input  logic [sstf_pkg::FIELD_W-1:0]    track,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [sstf_pkg::FIELD_W-1:0]    served_track,
  output logic [sstf_pkg::FIELD_W-1:0]    move_distance,
  output logic [sstf_pkg::TOTAL_W-1:0]    total_seek,
  output logic                            overflow,
  output logic                            final_res
);

  localparam int TW = (TRACK_BITS < sstf_pkg::FIELD_W) ? TRACK_BITS : sstf_pkg::FIELD_W;
  localparam int IW = $clog2(MAX_REQ);
  localparam int CW = $clog2(MAX_REQ + 1);

  logic [TW-1:0]      mem [MAX_REQ];
  logic [MAX_REQ-1:0] marks;
  logic [CW-1:0]      count;
  logic               dropped;
  logic [TW-1:0]      head_start;
  logic [TW-1:0]      head;
  logic [sstf_pkg::TOTAL_W-1:0] total;
  logic [IW-1:0]      pick;

  logic [IW-1:0]      scan_idx;
  logic [TW-1:0]      rd_data;
  logic [IW-1:0]      rd_idx;
  logic               rd_vld;

  logic               found;
  logic [IW-1:0]      best_idx;
  logic [TW-1:0]      best_trk;
  logic [TW-1:0]      best_d;

  logic               full;
  logic [TW-1:0]      cand_d;
  logic               take;
  logic [sstf_pkg::TOTAL_W:0]   total_sum;
  logic [sstf_pkg::TOTAL_W-1:0] total_next;
  logic [sstf_pkg::FIELD_W-1:0] trk_ext;
  logic [sstf_pkg::FIELD_W-1:0] dist_ext;

  assign full = (count == CW'(MAX_REQ));

  // Table write on load and registered read for the scan.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[IW-1:0]] <= track[TW-1:0];
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[scan_idx];
      rd_idx  <= scan_idx;
    end
  end

  always_comb begin
    cand_d = (head > rd_data) ? (head - rd_data) : (rd_data - head);
    take   = rd_vld && !marks[rd_idx] && (!found || (cand_d < best_d));

    total_sum = {1'b0, total} + (sstf_pkg::TOTAL_W + 1)'(best_d);
    if (total_sum > {1'b0, sstf_pkg::TOTAL_MAX}) begin
      total_next = sstf_pkg::TOTAL_MAX;
    end else begin
      total_next = total_sum[sstf_pkg::TOTAL_W-1:0];
    end

    trk_ext           = '0;
    trk_ext[TW-1:0]   = best_trk;
    dist_ext          = '0;
    dist_ext[TW-1:0]  = best_d;

    sts.scan_last = ((CW'(scan_idx) + CW'(1)) == count);
    sts.pick_last = ((CW'(pick) + CW'(1)) == count);
    sts.out_free  = !out_valid || !out_stall;
  end

  // Payload of the scan and the batch; no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      best_idx <= rd_idx;
      best_trk <= rd_data;
      best_d   <= cand_d;
    end
    if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (cmd.batch_start) begin
      head  <= head_start;
      total <= '0;
      pick  <= '0;
    end else if (cmd.commit) begin
      head  <= best_trk;
      total <= total_next;
      pick  <= pick + IW'(1);
    end
    if (cmd.commit) begin
      served_track  <= trk_ext;
      move_distance <= dist_ext;
      total_seek    <= total_next;
      overflow      <= dropped;
      final_res     <= sts.pick_last;
    end
  end

  // Control state and the head start register.
  always_ff @(posedge clk) begin
    if (rst) begin
      marks      <= '0;
      count      <= '0;
      dropped    <= 1'b0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
      head_start <= '0;
    end else begin
      if (cfg_we) begin
        head_start <= cfg_data[TW-1:0];
      end
      rd_vld <= cmd.scan_rd;
      if (cmd.scan_clear) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (cmd.batch_end) begin
        count   <= '0;
        dropped <= 1'b0;
        marks   <= '0;
      end else begin
        if (cmd.load) begin
          if (full) begin
            dropped <= 1'b1;
          end else begin
            count <= count + CW'(1);
          end
        end
        if (cmd.commit) begin
          marks[best_idx] <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SSTF_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_REQ), "request count above capacity")
  `SSTF_ASSERT_NOW(a_commit_free, clk, rst, cmd.commit, !out_valid || !out_stall, "commit overwrote a pending word")
  `SSTF_ASSERT_NEXT(a_batch_clear, clk, rst, cmd.batch_end, (marks == '0) && (count == '0) && !dropped, "batch state not cleared")
  `SSTF_ASSERT_NOW(a_commit_found, clk, rst, cmd.commit, found && !marks[best_idx], "commit without an unserved pick")

endmodule

// ----- src/sstf_disk_scheduler_top.sv -----
// Top level of the shortest-seek-time-first disk scheduler.
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_valid / cfg_ready cfg_data (head_start)
//   in        in         in_valid / in_stall   track, last
//   out       out        out_valid / out_stall served_track, move_distance,
//                                              total_seek, overflow, final_res
//
// Loading accepts one input word per cycle. Once the word marked last arrives, each
// pick scans every loaded entry through the one read port of the request table,
// then a wait state lets the compare take in the last entry before the pick is served.
// While a batch is served, in_stall stays high; a stalled output word holds the
// next pick in the serving state until the word is taken.
// Reset (rst, synchronous) empties the batch, clears served marks and head_start.
// The configuration port is always ready; write it only while the block is idle.
module sstf_disk_scheduler_top #(
  parameter int MAX_REQ    = 64,
  parameter int TRACK_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sstf_pkg::FIELD_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sstf_pkg::FIELD_W-1:0]    track,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sstf_pkg::FIELD_W-1:0]    served_track,
  output logic [sstf_pkg::FIELD_W-1:0]    move_distance,
  output logic [sstf_pkg::TOTAL_W-1:0]    total_seek,
  output logic                            overflow,
  output logic                            final_res
);

  sstf_pkg::cmd_t cmd;
  sstf_pkg::sts_t sts;
  logic           cfg_we;

  // The head start register sits in the datapath and can take a word any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  sstf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sstf_dp #(
    .MAX_REQ    (MAX_REQ),
    .TRACK_BITS (TRACK_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .track         (track),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .served_track  (served_track),
    .move_distance (move_distance),
    .total_seek    (total_seek),
    .overflow      (overflow),
    .final_res     (final_res)
  );

endmodule

// ----- sim/tb_sstf_disk_scheduler_top.sv -----
// Self-checking testbench for the SSTF disk scheduler with a predictor of each served word.
module tb_sstf_disk_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REQ       = 64;
  localparam int TRACK_BITS    = 16;
  // Cycles to let the block finish its batch clean-up after the final word.
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 64;
  localparam int REPORT_LIMIT  = 10;

  // One served word as the output channel presents it.
  typedef struct packed {
    logic [sstf_pkg::FIELD_W-1:0] served_track;
    logic [sstf_pkg::FIELD_W-1:0] move_distance;
    logic [sstf_pkg::TOTAL_W-1:0] total_seek;
    logic                         overflow;
    logic                         final_res;
  } pick_t;

  // Clock, reset and every block input start at a known value.
  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sstf_pkg::FIELD_W-1:0] cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic [sstf_pkg::FIELD_W-1:0] track     = '0;
  logic                         last      = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [sstf_pkg::FIELD_W-1:0] served_track;
  logic [sstf_pkg::FIELD_W-1:0] move_distance;
  logic [sstf_pkg::TOTAL_W-1:0] total_seek;
  logic                         overflow;
  logic                         final_res;

  // Predictor state: the request table, its fill level, the dropped flag and
  // a shadow of the head_start register.
  logic [sstf_pkg::FIELD_W-1:0] req_table [MAX_REQ];
  int unsigned                  req_count = 0;
  bit                           req_dropped = 1'b0;
  logic [sstf_pkg::FIELD_W-1:0] head_start_shadow = '0;

  // Served words predicted but not yet seen on the output channel.
  pick_t                        expected_picks [$];
  // Tracks of the batch that the next call of send_batch delivers.
  logic [sstf_pkg::FIELD_W-1:0] batch_q [$];
  int unsigned                  mismatch_count = 0;

  // When set, the matching side runs without any idle cycles.
  bit                           send_steady = 1'b0;
  bit                           recv_steady = 1'b0;

  always #5 clk = ~clk;

  sstf_disk_scheduler_top #(
    .MAX_REQ    (MAX_REQ),
    .TRACK_BITS (TRACK_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .track         (track),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .served_track  (served_track),
    .move_distance (move_distance),
    .total_seek    (total_seek),
    .overflow      (overflow),
    .final_res     (final_res)
  );

  // Idle length for either side: mostly none, often a few cycles, now and
  // then a long pause so that gaps land in every phase of a batch.
  function automatic int unsigned idle_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endfunction

  // Works out the whole service order of the batch just closed. Starting at
  // head_start, the nearest unserved request wins; the strict less-than keeps
  // the earliest loaded request on a tie. The running total saturates at the
  // top of its field, and every word of the batch carries the dropped flag.
  function automatic void schedule_batch();
    bit                           served [MAX_REQ];
    logic [sstf_pkg::FIELD_W-1:0] head;
    int unsigned                  total, best_d, d;
    int                           best;
    pick_t                        pick;
    head  = head_start_shadow;
    total = 0;
    for (int j = 0; j < MAX_REQ; j++) served[j] = 1'b0;
    for (int k = 0; k < req_count; k++) begin
      best   = -1;
      best_d = 0;
      for (int j = 0; j < req_count; j++) begin
        if (!served[j]) begin
          d = (head > req_table[j]) ? 32'(head - req_table[j]) : 32'(req_table[j] - head);
          if (best < 0 || d < best_d) begin
            best   = j;
            best_d = d;
          end
        end
      end
      served[best] = 1'b1;
      total = total + best_d;
      if (total > sstf_pkg::TOTAL_MAX) total = sstf_pkg::TOTAL_MAX;
      head = req_table[best];
      pick.served_track  = head;
      pick.move_distance = sstf_pkg::FIELD_W'(best_d);
      pick.total_seek    = sstf_pkg::TOTAL_W'(total);
      pick.overflow      = req_dropped;
      pick.final_res     = (k + 1 == req_count);
      expected_picks.push_back(pick);
    end
    req_count   = 0;
    req_dropped = 1'b0;
  endfunction

  // Applies one accepted request word to the predictor. Once the table is
  // full the word is lost, but a dropped word marked last still closes the batch.
  function automatic void record_request(input logic [sstf_pkg::FIELD_W-1:0] trk,
                                         input logic is_last);
    if (req_count < MAX_REQ) begin
      req_table[req_count] = trk;
      req_count++;
    end else begin
      req_dropped = 1'b1;
    end
    if (is_last) schedule_batch();
  endfunction

  // Offers one request word after a random gap and holds it until accepted.
  // Valid stays high on return so that the next word can follow without a bubble.
  task automatic send_request(input logic [sstf_pkg::FIELD_W-1:0] trk, input logic is_last);
    int unsigned gap;
    gap = idle_gap(send_steady);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    track    <= trk;
    last     <= is_last;
    do @(posedge clk); while (in_stall);
    record_request(trk, is_last);
  endtask

  task automatic send_batch();
    foreach (batch_q[i]) send_request(batch_q[i], i == batch_q.size() - 1);
    batch_q.delete();
  endtask

  task automatic fill_random(input int unsigned count);
    repeat (count) batch_q.push_back(sstf_pkg::FIELD_W'($urandom));
  endtask

  // Drops valid, waits until every predicted word has been taken, and then
  // gives the block time to clear its batch state.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The head position register is only written while the block is idle.
  task automatic write_head_start(input logic [sstf_pkg::FIELD_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    head_start_shadow = value;
  endtask

  // Single-request batches at both ends of the track range, served from a
  // head at either end, including the full-range move.
  task automatic test_single_requests();
    batch_q.push_back('1);
    send_batch();
    batch_q.push_back('0);
    send_batch();
    write_head_start('1);
    batch_q.push_back('0);
    send_batch();
    batch_q.push_back('1);
    send_batch();
  endtask

  // Equal distances on both sides of the head go to the earliest loaded
  // request, and duplicates of the head track are served with no movement.
  task automatic test_tie_break();
    write_head_start(sstf_pkg::FIELD_W'(1000));
    batch_q = {sstf_pkg::FIELD_W'(1010), sstf_pkg::FIELD_W'(990)};
    send_batch();
    batch_q = {sstf_pkg::FIELD_W'(990), sstf_pkg::FIELD_W'(1010), sstf_pkg::FIELD_W'(1000),
               sstf_pkg::FIELD_W'(1000), sstf_pkg::FIELD_W'(5)};
    send_batch();
  endtask

  // Alternating bit patterns and the range extremes around a head in the middle.
  task automatic test_field_extremes();
    write_head_start(sstf_pkg::FIELD_W'(16'h8000));
    batch_q = {sstf_pkg::FIELD_W'(16'h0000), sstf_pkg::FIELD_W'(16'hFFFF),
               sstf_pkg::FIELD_W'(16'hAAAA), sstf_pkg::FIELD_W'(16'h5555),
               sstf_pkg::FIELD_W'(16'h8000), sstf_pkg::FIELD_W'(16'h7FFF)};
    send_batch();
  endtask

  // A batch that fills the table exactly, then loses one plain word and
  // finally the word marked last, which still closes the batch.
  task automatic test_table_full();
    write_head_start(sstf_pkg::FIELD_W'($urandom));
    fill_random(MAX_REQ + 2);
    send_batch();
  endtask

  // Random batches, mostly small with the odd one near the table size. Half
  // of the tracks cluster around one point so that ties and repeats are common.
  task automatic test_random_batches();
    int unsigned                  sent, size, r;
    logic [sstf_pkg::FIELD_W-1:0] centre;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12) write_head_start('0);
      else if (r < 24) write_head_start('1);
      else if (r < 55) write_head_start(sstf_pkg::FIELD_W'($urandom));
      send_steady = ($urandom_range(0, 4) == 0);
      recv_steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) size = $urandom_range(1, 6);
      else if (r < 95) size = $urandom_range(7, 20);
      else size = $urandom_range(40, MAX_REQ);
      if (size > RANDOM_ITEMS - sent) size = RANDOM_ITEMS - sent;
      centre = $urandom_range(0, 1) ? head_start_shadow : sstf_pkg::FIELD_W'($urandom);
      repeat (size) begin
        if ($urandom_range(0, 1)) batch_q.push_back(sstf_pkg::FIELD_W'($urandom));
        else batch_q.push_back(centre + sstf_pkg::FIELD_W'($urandom_range(0, 8))
                               - sstf_pkg::FIELD_W'(4));
      end
      send_batch();
      sent += size;
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  // The output side stalls in random bursts; during steady stretches it never does.
  initial begin : out_stall_driver
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = idle_gap(recv_steady);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Every word taken from the output channel is compared, field by field,
  // with the oldest prediction. A word with nothing predicted is a failure too.
  always @(posedge clk) begin
    pick_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf(
          "unexpected word: track %0d dist %0d total %0d overflow %0b final %0b",
          served_track, move_distance, total_seek, overflow, final_res));
      end else begin
        want = expected_picks.pop_front();
        if (served_track !== want.served_track || move_distance !== want.move_distance ||
            total_seek !== want.total_seek || overflow !== want.overflow ||
            final_res !== want.final_res) begin
          report_mismatch({
            $sformatf("word mismatch: expected track %0d dist %0d total %0d",
                      want.served_track, want.move_distance, want.total_seek),
            $sformatf(" overflow %0b final %0b,", want.overflow, want.final_res),
            $sformatf(" got track %0d dist %0d total %0d overflow %0b final %0b",
                      served_track, move_distance, total_seek, overflow, final_res)});
        end
      end
    end
  end

  // Reset is held at first, then the tests run in turn. The run ends
  // once every predicted word has arrived and the block has had time to
  // show any stray output.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_single_requests();
    test_tie_break();
    test_field_extremes();
    test_table_full();
    test_random_batches();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
